[rtl/lc3_instruction_executor_defines.svh]
// assertion helpers used by the executor top level
`ifndef LC3_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define LC3_INSTRUCTION_EXECUTOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LC3IE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LC3IE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lc3ie_pkg.sv]
`timescale 1ns / 1ps
package lc3ie_pkg;

    localparam int ADDR_BITS = 16;
    localparam int MEM_WORDS = 1 << ADDR_BITS;

    typedef logic [ADDR_BITS-1:0] t_maddr;

    // item kinds carried in tuser
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_EXEC  = 2'd2;

    // instruction opcodes
    localparam logic [3:0] OPC_BR   = 4'd0;
    localparam logic [3:0] OPC_ADD  = 4'd1;
    localparam logic [3:0] OPC_LD   = 4'd2;
    localparam logic [3:0] OPC_ST   = 4'd3;
    localparam logic [3:0] OPC_JSR  = 4'd4;
    localparam logic [3:0] OPC_AND  = 4'd5;
    localparam logic [3:0] OPC_LDR  = 4'd6;
    localparam logic [3:0] OPC_STR  = 4'd7;
    localparam logic [3:0] OPC_NOT  = 4'd9;
    localparam logic [3:0] OPC_LDI  = 4'd10;
    localparam logic [3:0] OPC_STI  = 4'd11;
    localparam logic [3:0] OPC_JMP  = 4'd12;
    localparam logic [3:0] OPC_LEA  = 4'd14;
    localparam logic [3:0] OPC_TRAP = 4'd15;

    // trap vectors
    localparam logic [7:0] TRAP_GETC = 8'h20;
    localparam logic [7:0] TRAP_OUT  = 8'h21;
    localparam logic [7:0] TRAP_IN   = 8'h23;
    localparam logic [7:0] TRAP_HALT = 8'h25;

    // memory follow-up after execute
    localparam logic [2:0] MA_NONE  = 3'd0;
    localparam logic [2:0] MA_LOAD  = 3'd1;
    localparam logic [2:0] MA_LDI   = 3'd2;
    localparam logic [2:0] MA_STORE = 3'd3;
    localparam logic [2:0] MA_STI   = 3'd4;

    localparam logic [15:0] RESET_PC = 16'h3000;

    typedef struct packed {
        logic        we;
        logic [2:0]  idx;
        logic [15:0] data;
    } t_rf_wr;

    typedef struct packed {
        logic        wv;
        logic [2:0]  widx;
        logic [15:0] wval;
        logic        cc_upd;
        logic [2:0]  mem_act;
        logic [15:0] ea;
        logic [15:0] pc_next;
        logic        cv;
        logic [7:0]  ch;
        logic        halt;
    } t_exec;

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        logic [2:0] r;
        if (v[15]) begin
            r = 3'b100;
        end else if (v == 16'd0) begin
            r = 3'b010;
        end else begin
            r = 3'b001;
        end
        return r;
    endfunction

endpackage

[rtl/lc3ie_regfile.sv]
`timescale 1ns / 1ps
module lc3ie_regfile
    import lc3ie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rf_wr      i_wr,
    input  logic [2:0]  i_ra,
    input  logic [2:0]  i_rb,
    output logic [15:0] o_rd_a,
    output logic [15:0] o_rd_b
);

    logic [15:0] r_mem [8];
    logic [7:0]  r_valid;
    logic [15:0] r_rd_a;
    logic [15:0] r_rd_b;

    // entries not yet written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        r_rd_a <= r_valid[i_ra] ? r_mem[i_ra] : 16'd0;
        r_rd_b <= r_valid[i_rb] ? r_mem[i_rb] : 16'd0;
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

[rtl/lc3ie_exec.sv]
`timescale 1ns / 1ps
module lc3ie_exec
    import lc3ie_pkg::*;
(
    input  logic [15:0] i_ir,
    input  logic [15:0] i_pc,
    input  logic [15:0] i_rf_a,
    input  logic [15:0] i_rf_b,
    input  logic [2:0]  i_cc,
    input  logic [7:0]  i_key,
    output t_exec       o_ex
);

    logic [3:0]  opc;
    logic [2:0]  dr;
    logic        reg_base;
    logic [15:0] offs;
    logic [15:0] base;
    logic [15:0] sum;
    logic [15:0] opnd_b;

    assign opc      = i_ir[15:12];
    assign dr       = i_ir[11:9];
    assign reg_base = (opc == OPC_LDR) || (opc == OPC_STR);

    // one address adder shared by branches, jsr, loads, stores and lea
    always_comb begin
        if (opc == OPC_JSR) begin
            offs = {{5{i_ir[10]}}, i_ir[10:0]};
        end else if (reg_base) begin
            offs = {{10{i_ir[5]}}, i_ir[5:0]};
        end else begin
            offs = {{7{i_ir[8]}}, i_ir[8:0]};
        end
        base = reg_base ? i_rf_a : i_pc;
        sum  = base + offs;
        opnd_b = i_ir[5] ? {{11{i_ir[4]}}, i_ir[4:0]} : i_rf_b;
    end

    always_comb begin
        o_ex         = '0;
        o_ex.mem_act = MA_NONE;
        o_ex.ea      = sum;
        o_ex.pc_next = i_pc;
        unique case (opc) inside
            OPC_ADD: begin
                o_ex.wv = 1'b1; o_ex.widx = dr; o_ex.cc_upd = 1'b1;
                o_ex.wval = i_rf_a + opnd_b;
            end
            OPC_AND: begin
                o_ex.wv = 1'b1; o_ex.widx = dr; o_ex.cc_upd = 1'b1;
                o_ex.wval = i_rf_a & opnd_b;
            end
            OPC_NOT: begin
                o_ex.wv = 1'b1; o_ex.widx = dr; o_ex.cc_upd = 1'b1;
                o_ex.wval = ~i_rf_a;
            end
            OPC_LEA: begin
                o_ex.wv = 1'b1; o_ex.widx = dr; o_ex.cc_upd = 1'b1;
                o_ex.wval = sum;
            end
            OPC_BR: begin
                if ((dr & i_cc) != 3'd0) begin
                    o_ex.pc_next = sum;
                end
            end
            OPC_JMP: begin
                o_ex.pc_next = i_rf_a;
            end
            OPC_JSR: begin
                // link is written without touching the flags
                o_ex.wv = 1'b1; o_ex.widx = 3'd7; o_ex.wval = i_pc;
                o_ex.pc_next = i_ir[11] ? sum : i_rf_a;
            end
            OPC_LD, OPC_LDR: begin
                o_ex.wv = 1'b1; o_ex.widx = dr; o_ex.mem_act = MA_LOAD;
            end
            OPC_LDI: begin
                o_ex.wv = 1'b1; o_ex.widx = dr; o_ex.mem_act = MA_LDI;
            end
            OPC_ST, OPC_STR: begin
                o_ex.mem_act = MA_STORE;
            end
            OPC_STI: begin
                o_ex.mem_act = MA_STI;
            end
            OPC_TRAP: begin
                case (i_ir[7:0]) inside
                    TRAP_GETC, TRAP_IN: begin
                        o_ex.wv = 1'b1; o_ex.widx = 3'd0;
                        o_ex.wval = {8'd0, i_key};
                    end
                    TRAP_OUT: begin
                        o_ex.cv = 1'b1; o_ex.ch = i_rf_a[7:0];
                    end
                    TRAP_HALT: begin
                        o_ex.halt = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                // rti and the reserved opcode only step the pc
            end
        endcase
    end

endmodule

[rtl/lc3_instruction_executor.sv]
// lc3 executor: one beat in, one result beat out, in order
// a typical instruction passes through fetch, register read, execute and result load;
// loads add one main-memory read each on the single read port, ldi two
// a new beat is taken while a finished result still sits in the output register
// reset (synchronous, active low): pc 0x3000, registers zero, flags clear, not halted
`timescale 1ns / 1ps
`include "lc3_instruction_executor_defines.svh"
module lc3_instruction_executor
    import lc3ie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config: start pc, also loads the pc at once
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // address[15:0], data[31:16], key_char[39:32]
    input  logic [1:0]  s_axis_tuser,  // op[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // pc[15:0], cond_codes[18:16], reg_write_valid[19],
                                       // reg_index[22:20], reg_value[38:23], char_valid[39],
                                       // char_out[47:40], halted[48], read_data[64:49],
                                       // zero[71:65]
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_EXE  = 3'd3;
    localparam logic [2:0] S_LD1  = 3'd4;
    localparam logic [2:0] S_LD2  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]  r_state;
    logic [15:0] r_pc;
    logic [2:0]  r_cc;
    logic        r_halt;
    logic [15:0] r_ir;
    logic [7:0]  r_key;
    logic [2:0]  r_mem_act;

    // result fields collected while the item runs
    logic        r_res_wv;
    logic [2:0]  r_res_widx;
    logic [15:0] r_res_wval;
    logic        r_res_cv;
    logic [7:0]  r_res_ch;
    logic [15:0] r_res_rdata;

    // output register
    logic        r_out_valid;
    logic [71:0] r_out_tdata;

    // main memory, one write and one read port, registered read
    logic [15:0] r_mem [MEM_WORDS];
    logic [15:0] r_mem_rdata;
    logic        mem_we;
    t_maddr      mem_waddr;
    logic [15:0] mem_wdata;
    t_maddr      mem_raddr;

    logic        accept;
    logic [15:0] ir_src;
    logic [3:0]  opc_src;
    logic [2:0]  rf_ra;
    logic [2:0]  rf_rb;
    logic [15:0] rf_a;
    logic [15:0] rf_b;
    t_rf_wr      rf_wr;
    t_exec       ex;
    logic        out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign out_free      = !r_out_valid || m_axis_tready;

    // register reads: straight from the fetched word in decode, from ir after that,
    // so the read data stays put for the rest of the item
    always_comb begin
        ir_src  = (r_state == S_DEC) ? r_mem_rdata : r_ir;
        opc_src = ir_src[15:12];
        rf_ra   = (opc_src == OPC_TRAP) ? 3'd0 : ir_src[8:6];
        case (opc_src) inside
            OPC_ST, OPC_STI, OPC_STR: rf_rb = ir_src[11:9];
            default:                  rf_rb = ir_src[2:0];
        endcase
    end

    lc3ie_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (rf_wr),
        .i_ra    (rf_ra),
        .i_rb    (rf_rb),
        .o_rd_a  (rf_a),
        .o_rd_b  (rf_b)
    );

    lc3ie_exec u_exec (
        .i_ir    (r_ir),
        .i_pc    (r_pc),
        .i_rf_a  (rf_a),
        .i_rf_b  (rf_b),
        .i_cc    (r_cc),
        .i_key   (r_key),
        .o_ex    (ex)
    );

    // memory port steering; the sequencer keeps every write and the later
    // reads of the same word in separate cycles, so no forwarding is needed
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ex.ea[ADDR_BITS-1:0];
        mem_wdata = rf_b;
        mem_raddr = ex.ea[ADDR_BITS-1:0];
        rf_wr     = '0;
        unique case (r_state)
            S_IDLE: begin
                mem_we    = accept && (s_axis_tuser == OP_WRITE);
                mem_waddr = s_axis_tdata[ADDR_BITS-1:0];
                mem_wdata = s_axis_tdata[31:16];
                mem_raddr = (s_axis_tuser == OP_READ) ? s_axis_tdata[ADDR_BITS-1:0]
                                                      : r_pc[ADDR_BITS-1:0];
            end
            S_EXE: begin
                mem_we     = (ex.mem_act == MA_STORE);
                rf_wr.we   = ex.wv && (ex.mem_act == MA_NONE);
                rf_wr.idx  = ex.widx;
                rf_wr.data = ex.wval;
            end
            S_LD1: begin
                // pointer word for ldi and sti, load data for ld and ldr
                mem_we     = (r_mem_act == MA_STI);
                mem_waddr  = r_mem_rdata[ADDR_BITS-1:0];
                mem_raddr  = r_mem_rdata[ADDR_BITS-1:0];
                rf_wr.we   = (r_mem_act == MA_LOAD);
                rf_wr.idx  = r_res_widx;
                rf_wr.data = r_mem_rdata;
            end
            S_LD2: begin
                rf_wr.we   = 1'b1;
                rf_wr.idx  = r_res_widx;
                rf_wr.data = r_mem_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_rdata <= r_mem[mem_raddr];
    end

    // sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= RESET_PC;
            r_cc        <= 3'd0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output register loads from finish, drains on the result handshake
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_key       <= s_axis_tdata[39:32];
                        r_res_wv    <= 1'b0;
                        r_res_widx  <= 3'd0;
                        r_res_wval  <= 16'd0;
                        r_res_cv    <= 1'b0;
                        r_res_ch    <= 8'd0;
                        r_res_rdata <= 16'd0;
                        if (s_axis_tuser == OP_READ) begin
                            r_state <= S_RD;
                        end else if (s_axis_tuser == OP_EXEC && !r_halt) begin
                            r_state <= S_DEC;
                        end else begin
                            // write, unused op, or execute while halted
                            r_state <= S_FIN;
                        end
                    end
                end
                S_RD: begin
                    r_res_rdata <= r_mem_rdata;
                    r_state     <= S_FIN;
                end
                S_DEC: begin
                    r_ir    <= r_mem_rdata;
                    r_pc    <= r_pc + 16'd1;
                    r_state <= S_EXE;
                end
                S_EXE: begin
                    r_pc       <= ex.pc_next;
                    r_res_wv   <= ex.wv;
                    r_res_widx <= ex.widx;
                    r_res_wval <= ex.wval;
                    r_res_cv   <= ex.cv;
                    r_res_ch   <= ex.ch;
                    r_mem_act  <= ex.mem_act;
                    if (ex.cc_upd) begin
                        r_cc <= cc_of(ex.wval);
                    end
                    if (ex.halt) begin
                        r_halt <= 1'b1;
                    end
                    if (ex.mem_act == MA_LOAD || ex.mem_act == MA_LDI
                            || ex.mem_act == MA_STI) begin
                        r_state <= S_LD1;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_LD1: begin
                    if (r_mem_act == MA_LOAD) begin
                        r_res_wval <= r_mem_rdata;
                        r_cc       <= cc_of(r_mem_rdata);
                        r_state    <= S_FIN;
                    end else if (r_mem_act == MA_LDI) begin
                        r_state <= S_LD2;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_LD2: begin
                    r_res_wval <= r_mem_rdata;
                    r_cc       <= cc_of(r_mem_rdata);
                    r_state    <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // the user must send config only with the block idle; the block does not enforce it
            if (i_cfg_valid && o_cfg_ready) begin
                r_pc <= i_cfg_data;
            end
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_out_tdata <= {7'd0, r_res_rdata, r_halt, r_res_ch, r_res_cv, r_res_wval,
                            r_res_widx, r_res_wv, r_cc, r_pc};
        end
    end

    // a store never shares a cycle with a register write
    `LC3IE_ASSERT_NOW(a_no_dual_write, i_clk, i_rst_n, mem_we, !rf_wr.we,
        "memory and register file written in the same cycle")

    // halt is sticky until reset
    `LC3IE_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_halt, r_halt,
        "halt flag dropped without reset")

    // an accepted instruction while running goes to fetch decode
    `LC3IE_ASSERT_NEXT(a_exec_fetch, i_clk, i_rst_n,
        accept && s_axis_tuser == OP_EXEC && !r_halt, r_state == S_DEC,
        "instruction accepted but no fetch followed")

    // finishing an item always leaves a result in the output register
    `LC3IE_ASSERT_NEXT(a_fin_result, i_clk, i_rst_n,
        r_state == S_FIN && out_free, r_out_valid && r_state == S_IDLE,
        "finished item did not reach the output register")

endmodule
